// File: src/temperature_seven_segment_scanner_unit_defines.svh
// Assertion macros shared by the scanner unit
`ifndef TEMPERATURE_SEVEN_SEGMENT_SCANNER_UNIT_DEFINES_SVH
`define TEMPERATURE_SEVEN_SEGMENT_SCANNER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while in reset
`define TSSU_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("scanner unit assertion failed");

// Next-cycle implication, disabled while in reset
`define TSSU_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("scanner unit assertion failed");

`endif

// File: src/tssu_pkg.sv
// Types, constants and glyph table for the temperature scanner unit
package tssu_pkg;

  localparam logic       MODE_UPDATE = 1'b0;
  localparam logic       MODE_SCAN   = 1'b1;

  localparam logic [7:0] LETTER_C    = 8'hC6;
  localparam logic [7:0] DP_MASK     = 8'h80;
  localparam logic [7:0] SEG_OFF     = 8'hFF;
  localparam logic [3:0] EN_OFF      = 4'hF;
  localparam logic [6:0] WHOLE_MAX   = 7'd99;

  // q = (t * 52429) >> 19 equals t / 10 for every t below 32768
  localparam logic [15:0] TEN_RECIP  = 16'd52429;
  localparam int          RECIP_SHIFT = 19;

  typedef logic [3:0][7:0] tssu_codes_t;

  typedef struct packed {
    logic fire;
    logic scan;
  } tssu_step_t;

  typedef struct packed {
    logic [7:0] segments;
    logic [3:0] enables;
  } tssu_pins_t;

  function automatic logic [7:0] digit_glyph(input logic [3:0] digit);
    logic [7:0] code;
    case (digit)
      4'd0:    code = 8'hC0;
      4'd1:    code = 8'hF9;
      4'd2:    code = 8'hA4;
      4'd3:    code = 8'hB0;
      4'd4:    code = 8'h99;
      4'd5:    code = 8'h92;
      4'd6:    code = 8'h82;
      4'd7:    code = 8'hF8;
      4'd8:    code = 8'h80;
      4'd9:    code = 8'h90;
      default: code = SEG_OFF;
    endcase
    return code;
  endfunction

endpackage

// File: src/temperature_seven_segment_scanner_unit.sv
// Channel  | Signals                                  | Carries
// s_axis   | tvalid tready tdata[15:0] tuser          | temperature_tenths, mode
// m_axis   | tvalid tready tdata[15:0]                | segment_lines, digit_enables
//
// One transaction per cycle sustained while m_axis_tready stays high; the path runs through the input
// register, then the result register, with the single multiply-and-select pass between them.
// Reset clears both stages, the digit buffer to zero and the pins to all off.
// With m_axis_tready low the result holds and one more transaction waits in the
// input register; s_axis_tready then drops until the result is taken.
`include "temperature_seven_segment_scanner_unit_defines.svh"

// Top level of the multiplexed seven-segment temperature scanner
module temperature_seven_segment_scanner_unit
  import tssu_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] temperature_tenths (signed)
  input  logic        s_axis_tuser,   // [0] mode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // [7:0] segment_lines, [11:8] digit_enables, [15:12] zero
);

  logic               in_valid;
  logic               in_mode;
  logic signed [15:0] in_temp;
  logic               out_ready;
  tssu_step_t         step;
  tssu_codes_t        codes_new;
  tssu_pins_t         pins_next;
  tssu_pins_t         out_pins;

  assign out_ready     = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = !in_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_mode <= s_axis_tuser;
      in_temp <= signed'(s_axis_tdata);
    end
  end

  assign step.fire = in_valid && out_ready;
  assign step.scan = (in_mode == MODE_SCAN);

  tssu_temp_decode u_decode (
    .temperature_tenths (in_temp),
    .codes              (codes_new)
  );

  tssu_scan_core u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .codes_new (codes_new),
    .pins_next (pins_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_ready) begin
      m_axis_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step.fire) begin
      out_pins <= pins_next;
    end
  end

  assign m_axis_tdata = {4'b0000, out_pins.enables, out_pins.segments};

  // At most one digit enabled on any delivered result
  `TSSU_ASSERT_SAME(a_one_digit, clk, rst, m_axis_tvalid, $countones(m_axis_tdata[11:8]) >= 3)
  // A waiting transaction is never dropped while the result stage is blocked
  `TSSU_ASSERT_NEXT(a_in_hold, clk, rst, in_valid && !out_ready, in_valid)
  // A transaction that leaves the input stage shows up as a result
  `TSSU_ASSERT_NEXT(a_out_fill, clk, rst, step.fire, m_axis_tvalid)

endmodule

// File: src/tssu_temp_decode.sv
// Splits a temperature in tenths into clamped digits and segment codes
module tssu_temp_decode
  import tssu_pkg::*;
(
  input  logic signed [15:0] temperature_tenths,
  output tssu_codes_t        codes
);

  logic        negative;
  logic [14:0] magnitude;
  logic [30:0] product;
  logic [11:0] quotient;
  logic [14:0] quotient_ten;
  logic [14:0] remainder_wide;
  logic [6:0]  whole;
  logic [3:0]  tenths;
  logic [3:0]  tens;
  logic [6:0]  tens_ten;
  logic [6:0]  units_wide;

  assign negative  = temperature_tenths[15];
  assign magnitude = temperature_tenths[14:0];

  assign product        = 31'(magnitude) * 31'(TEN_RECIP);
  assign quotient       = product[RECIP_SHIFT +: 12];
  assign quotient_ten   = 15'({quotient, 3'b000}) + 15'({quotient, 1'b0});
  assign remainder_wide = magnitude - quotient_ten;

  // Negative input: whole part and tenths both show as zero
  always_comb begin
    if (negative) begin
      whole  = 7'd0;
      tenths = 4'd0;
    end else begin
      whole  = (quotient > 12'(WHOLE_MAX)) ? WHOLE_MAX : quotient[6:0];
      tenths = remainder_wide[3:0];
    end
  end

  always_comb begin
    tens = 4'd0;
    for (int k = 1; k <= 9; k++) begin
      if (whole >= 7'(10 * k)) tens = 4'(k);
    end
  end

  assign tens_ten   = 7'({tens, 3'b000}) + 7'({tens, 1'b0});
  assign units_wide = whole - tens_ten;

  assign codes[0] = digit_glyph(tens);
  assign codes[1] = digit_glyph(units_wide[3:0]) & ~DP_MASK;
  assign codes[2] = digit_glyph(tenths);
  assign codes[3] = LETTER_C;

endmodule

// File: src/tssu_scan_core.sv
// Digit buffer, scan index and pin state of the display driver
module tssu_scan_core
  import tssu_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  tssu_step_t  step,
  input  tssu_codes_t codes_new,
  output tssu_pins_t  pins_next
);

  tssu_codes_t digit_codes;
  logic [1:0]  scan_index;
  logic [1:0]  scan_index_next;
  tssu_pins_t  pins;

  assign scan_index_next = scan_index + 2'd1;

  // Advance first, then show the new entry; an update leaves the pins alone
  always_comb begin
    pins_next = pins;
    if (step.scan) begin
      pins_next.segments = digit_codes[scan_index_next];
      pins_next.enables  = ~(4'b0001 << scan_index_next);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      digit_codes <= '0;
      scan_index  <= 2'd0;
      pins        <= '{segments: SEG_OFF, enables: EN_OFF};
    end else if (step.fire) begin
      if (step.scan) begin
        scan_index <= scan_index_next;
        pins       <= pins_next;
      end else begin
        digit_codes <= codes_new;
      end
    end
  end

endmodule

// File: tb/temperature_seven_segment_scanner_unit_tb.sv
// Testbench for the seven-segment temperature scanner: directed table, random bursts, scoreboard
module temperature_seven_segment_scanner_unit_tb;
  import tssu_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_ITEMS = 1500;
  localparam int LONG_HOLD    = 300;
  localparam int DRAIN_CYCLES = 10;
  localparam int N_DIRECTED   = 24;

  // glyphs for digits 9 down to 0, so GLYPHS[d] is the code of digit d
  localparam logic [9:0][7:0] GLYPHS = {
    8'h90, 8'h80, 8'hF8, 8'h82, 8'h92, 8'h99, 8'hB0, 8'hA4, 8'hF9, 8'hC0
  };

  typedef struct packed {
    logic [7:0] segs;
    logic [3:0] ens;
  } pin_state_t;

  typedef struct packed {
    logic       mode;
    logic [15:0] temp;
    logic       checked;
    logic [7:0] segs;
    logic [3:0] ens;
  } row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;   // [15:0] temperature_tenths (signed)
  logic        s_axis_tuser = 1'b0; // [0] mode
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;        // [7:0] segment_lines, [11:8] digit_enables

  // typed expectation that travels with the current directed row
  logic        row_checked = 1'b0;
  pin_state_t  row_pins = '0;

  int hold_requests = 0;
  int holds_done    = 0;
  int hold_left     = 0;
  int stall_style   = 0;
  int stall_cycles  = 0;
  int cycle_count   = 0;
  int mismatch_count = 0;

  // display predictor state
  logic [7:0] shown_codes [4];
  logic [1:0] scan_pos;
  logic [7:0] seg_state;
  logic [3:0] en_state;

  pin_state_t expected_pins [$];
  row_t       directed_rows [N_DIRECTED];

  temperature_seven_segment_scanner_unit i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic pin_state_t step_display(input logic mode, input logic [15:0] raw);
    int t;
    int whole;
    int tenth;
    pin_state_t r;
    t = $signed(raw);
    if (mode == MODE_UPDATE) begin
      whole = t / 10;
      tenth = t % 10;
      if (whole < 0) whole = 0;
      if (whole > int'(WHOLE_MAX)) whole = int'(WHOLE_MAX);
      if (tenth < 0) tenth = 0;
      shown_codes[0] = GLYPHS[whole / 10];
      shown_codes[1] = GLYPHS[whole % 10] & ~DP_MASK;
      shown_codes[2] = GLYPHS[tenth];
      shown_codes[3] = LETTER_C;
    end else begin
      scan_pos  = scan_pos + 2'd1;
      seg_state = shown_codes[scan_pos];
      en_state  = ~(4'b0001 << scan_pos);
    end
    r.segs = seg_state;
    r.ens  = en_state;
    return r;
  endfunction

  task automatic flag_failure(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%s", msg);
  endtask

  // scoreboard: predict on input transactions, compare on output transactions
  always @(posedge clk) begin : scoreboard
    pin_state_t want;
    if (rst) begin
      for (int i = 0; i < 4; i++) shown_codes[i] = 8'h00;
      scan_pos  = 2'd0;
      seg_state = SEG_OFF;
      en_state  = EN_OFF;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        want = step_display(s_axis_tuser, s_axis_tdata);
        if (row_checked) want = row_pins;
        expected_pins.push_back(want);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_pins.size() == 0) begin
          flag_failure($sformatf("unexpected result %h", m_axis_tdata));
        end else begin
          want = expected_pins.pop_front();
          if (m_axis_tdata[7:0] !== want.segs || m_axis_tdata[11:8] !== want.ens ||
              m_axis_tdata[15:12] !== 4'h0)
            flag_failure($sformatf("mismatch: segments exp %h got %h, enables exp %h got %h",
                                   want.segs, m_axis_tdata[7:0], want.ens, m_axis_tdata[11:8]));
        end
      end
    end
  end

  // receiver: changing stall pattern, plus long hold-offs on request
  always @(posedge clk) begin
    stall_cycles <= stall_cycles + 1;
    if (stall_cycles % 128 == 0) stall_style <= $urandom_range(0, 3);
    if (hold_left != 0) begin
      m_axis_tready <= 1'b0;
      hold_left     <= hold_left - 1;
    end else if (hold_requests != holds_done) begin
      m_axis_tready <= 1'b0;
      hold_left     <= LONG_HOLD;
      holds_done    <= holds_done + 1;
    end else begin
      case (stall_style)
        0:       m_axis_tready <= 1'b1;
        1:       m_axis_tready <= 1'($urandom_range(0, 1));
        2:       m_axis_tready <= ($urandom_range(0, 3) != 0);
        default: m_axis_tready <= (stall_cycles % 3 != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // offer one transaction and hold it until accepted
  task automatic offer(input row_t r);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= r.mode;
    s_axis_tdata  <= r.temp;
    row_checked   <= r.checked;
    row_pins      <= '{segs: r.segs, ens: r.ens};
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic pause(input int n);
    if (n > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // look at the queue only after the scoreboard has seen the latest edge
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk); while (expected_pins.size() != 0);
    @(posedge clk);
  endtask

  function automatic logic [15:0] pick_temperature();
    logic [15:0] v;
    case ($urandom_range(0, 7))
      0: v = 16'($urandom);
      1: v = 16'($urandom_range(0, 1000));
      2: begin
        case ($urandom_range(0, 9))
          0: v = 16'h7FFF;
          1: v = 16'h8000;
          2: v = 16'd999;
          3: v = 16'd1000;
          4: v = 16'd990;
          5: v = -16'sd1;
          6: v = -16'sd9;
          7: v = -16'sd10;
          8: v = 16'd9;
          default: v = 16'd0;
        endcase
      end
      3: v = -$signed(16'($urandom_range(0, 200)));
      4: v = 16'($urandom_range(1000, 32767));
      default: v = 16'($urandom_range(0, 999));
    endcase
    return v;
  endfunction

  initial begin : stimulus
    row_t r;
    int burst_left;
    int no_gap_left;
    directed_rows = '{
      // scans before any update drive the cleared buffer
      '{MODE_SCAN,   16'h1234, 1'b1, 8'h00, 4'hD},
      '{MODE_SCAN,   16'hFFFF, 1'b1, 8'h00, 4'hB},
      '{MODE_SCAN,   16'h0000, 1'b1, 8'h00, 4'h7},
      '{MODE_SCAN,   16'h5A5A, 1'b1, 8'h00, 4'hE},
      // update leaves the pins alone
      '{MODE_UPDATE, 16'h7FFF, 1'b1, 8'h00, 4'hE},
      '{MODE_SCAN,   16'h0000, 1'b0, 8'h00, 4'h0},
      '{MODE_SCAN,   16'h0000, 1'b0, 8'h00, 4'h0},
      '{MODE_SCAN,   16'h0000, 1'b1, LETTER_C, 4'h7},
      '{MODE_SCAN,   16'h0000, 1'b0, 8'h00, 4'h0},
      '{MODE_UPDATE, 16'h8000, 1'b1, 8'h90, 4'hE},
      '{MODE_SCAN,   16'h0000, 1'b0, 8'h00, 4'h0},
      '{MODE_UPDATE, 16'hFFFF, 1'b0, 8'h00, 4'h0},
      '{MODE_UPDATE, 16'd1000, 1'b0, 8'h00, 4'h0},
      '{MODE_SCAN,   16'h0000, 1'b0, 8'h00, 4'h0},
      '{MODE_SCAN,   16'h0000, 1'b0, 8'h00, 4'h0},
      '{MODE_SCAN,   16'h0000, 1'b0, 8'h00, 4'h0},
      '{MODE_UPDATE, 16'd999,  1'b0, 8'h00, 4'h0},
      '{MODE_UPDATE, 16'd995,  1'b0, 8'h00, 4'h0},
      '{MODE_UPDATE, 16'd9,    1'b0, 8'h00, 4'h0},
      '{MODE_UPDATE, 16'd10,   1'b0, 8'h00, 4'h0},
      '{MODE_UPDATE, 16'hFFF6, 1'b0, 8'h00, 4'h0},
      '{MODE_SCAN,   16'h0000, 1'b0, 8'h00, 4'h0},
      '{MODE_SCAN,   16'h0000, 1'b0, 8'h00, 4'h0},
      '{MODE_SCAN,   16'h0000, 1'b0, 8'h00, 4'h0}
    };

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    for (int i = 0; i < N_DIRECTED; i++) begin
      offer(directed_rows[i]);
      pause($urandom_range(0, 1));
    end
    wait_drained();

    burst_left  = 0;
    no_gap_left = 0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // stall the receiver for a long stretch and keep offering back to back
      if (n == 400 || n == 1100) begin
        hold_requests <= hold_requests + 1;
        no_gap_left = 40;
      end
      if (n == 800) wait_drained();
      r.mode    = ($urandom_range(0, 9) < 6) ? MODE_SCAN : MODE_UPDATE;
      r.temp    = (r.mode == MODE_UPDATE) ? pick_temperature() : 16'($urandom);
      r.checked = 1'b0;
      r.segs    = 8'h00;
      r.ens     = 4'h0;
      offer(r);
      if (no_gap_left > 0) begin
        no_gap_left--;
      end else if (burst_left > 0) begin
        burst_left--;
      end else begin
        burst_left = $urandom_range(1, 20);
        pause($urandom_range(0, 8));
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_pins.size() != 0) flag_failure("results missing at end of run");
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
